### design/macd_crossover_signal_defines.svh
// ----------------------------------------------------------------------------
// MACD crossover signal - assertion macros
// Clocked assertion helpers used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef MACD_CROSSOVER_SIGNAL_DEFINES_SVH
`define MACD_CROSSOVER_SIGNAL_DEFINES_SVH

`ifndef ASSERT_OFF
// A property that must hold in the same cycle.
`define MACS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// A condition that must be followed by a consequence in the next cycle.
`define MACS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define MACS_ASSERT(label, clk, rstn, prop, msg)
`define MACS_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif

`endif

### design/macs_pkg.sv
// ----------------------------------------------------------------------------
// MACD crossover signal - package
// Shared constants, codes, types and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package macs_pkg;

    // Default parameter values.
    localparam int PRICE_BITS_DEF      = 32;
    localparam int EXTRA_FRAC_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF      = 16;

    // Fixed field widths.
    localparam int ALPHA_BITS   = 17;
    localparam int ALPHA_FRAC   = 16;
    localparam int WARMUP_BITS  = 16;
    localparam int OUT_BITS     = 49;
    localparam int KIND_BITS    = 2;
    localparam int S_USER_BITS  = 5;
    localparam int M_USER_BITS  = 2;
    localparam int M_DATA_BITS  = ((2 * OUT_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = ALPHA_BITS'(1 << ALPHA_FRAC);

    // Tick kinds.
    localparam logic [KIND_BITS-1:0] TICK_NONE  = 2'd0;
    localparam logic [KIND_BITS-1:0] TICK_QUOTE = 2'd1;
    localparam logic [KIND_BITS-1:0] TICK_TRADE = 2'd2;

    // Signal kinds.
    localparam logic [KIND_BITS-1:0] SIG_HOLD = 2'd0;
    localparam logic [KIND_BITS-1:0] SIG_BUY  = 2'd1;
    localparam logic [KIND_BITS-1:0] SIG_SELL = 2'd2;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_FAST   = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_SLOW   = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_SIGNAL = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WARMUP       = 8'd3;

    // Register reset values.
    localparam logic [ALPHA_BITS-1:0]  ALPHA_FAST_RST   = 17'd10082;
    localparam logic [ALPHA_BITS-1:0]  ALPHA_SLOW_RST   = 17'd4855;
    localparam logic [ALPHA_BITS-1:0]  ALPHA_SIGNAL_RST = 17'd13107;
    localparam logic [WARMUP_BITS-1:0] WARMUP_RST       = 16'd78;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAST_GO,
        ST_FAST_WAIT,
        ST_SLOW_GO,
        ST_SLOW_WAIT,
        ST_MACD,
        ST_SIG_GO,
        ST_SIG_WAIT,
        ST_OUTPUT
    } macs_state_t;

    typedef struct packed {
        logic                  start;
        logic [ALPHA_BITS-1:0] alpha;
    } blend_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } blend_rsp_t;

    // Weights above one act as one.
    function automatic logic [ALPHA_BITS-1:0] clamp_alpha(input logic [ALPHA_BITS-1:0] a);
        return (a > ALPHA_ONE) ? ALPHA_ONE : a;
    endfunction

endpackage

`default_nettype wire

### design/macd_crossover_signal.sv
// ----------------------------------------------------------------------------
// MACD crossover signal generator
// Tracks fast and slow price EMAs, the MACD line and its signal line, and
// reports BUY or SELL when the MACD line crosses the signal line.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Contents
//  s_       in         s_tvalid/s_tready   one market tick per transfer
//  m_       out        m_tvalid/m_tready   one signal result per tick
//  cfg_     in         cfg_valid/cfg_ready register index and write data
//
// A tick with a usable price runs the fast, slow and signal blends in turn,
// each walking NCH = ceil((PRICE_BITS+EXTRA_FRAC_BITS+2)/32) 32-bit slices
// on the shared blend multiplier; a tick without a price goes straight to
// the output. The input is ready only while idle; a stalled m_ side holds
// the sequencer only once a second result is ready.
// Reset is synchronous on aresetn. Configuration writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "macd_crossover_signal_defines.svh"

module macd_crossover_signal #(
    parameter int PRICE_BITS      = macs_pkg::PRICE_BITS_DEF,
    parameter int EXTRA_FRAC_BITS = macs_pkg::EXTRA_FRAC_BITS_DEF,
    parameter int COUNT_BITS      = macs_pkg::COUNT_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Tick input.
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // bid_price, ask_price, trade_price, zero padding
    input  logic [((3*PRICE_BITS+7)/8)*8-1:0]       s_tdata,
    // tick_kind[1:0], bid_valid, ask_valid, trade_valid
    input  logic [macs_pkg::S_USER_BITS-1:0]        s_tuser,
    // Result output.
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // macd_value[48:0], signal_line[48:0], zero padding
    output logic [macs_pkg::M_DATA_BITS-1:0]        m_tdata,
    // signal_kind[1:0]
    output logic [macs_pkg::M_USER_BITS-1:0]        m_tuser,
    // Configuration writes.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [macs_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [macs_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import macs_pkg::*;

    localparam int EMA_BITS   = PRICE_BITS + EXTRA_FRAC_BITS;
    localparam int BLEND_BITS = EMA_BITS + 2;
    localparam int WIDE_BITS  = 66;
    localparam int CMP_BITS   = 32;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    macs_state_t state_reg, state_next;

    logic [ALPHA_BITS-1:0]  alpha_fast_reg;
    logic [ALPHA_BITS-1:0]  alpha_slow_reg;
    logic [ALPHA_BITS-1:0]  alpha_signal_reg;
    logic [WARMUP_BITS-1:0] warmup_reg;

    // Running state of the indicator.
    logic [EMA_BITS-1:0]        fast_reg;
    logic [EMA_BITS-1:0]        slow_reg;
    logic signed [EMA_BITS:0]   macd_reg;
    logic signed [EMA_BITS:0]   trig_reg;
    logic                       seeded_reg;
    logic [COUNT_BITS-1:0]      count_reg;

    // Per-tick working values.
    logic [EMA_BITS-1:0]        x_reg;
    logic                       have_reg;
    logic                       armed_reg;
    logic signed [EMA_BITS:0]   last_macd_reg;
    logic signed [EMA_BITS:0]   last_trig_reg;

    // Output register.
    logic                       m_valid_reg;
    logic [KIND_BITS-1:0]       out_kind_reg;
    logic [OUT_BITS-1:0]        out_macd_reg;
    logic [OUT_BITS-1:0]        out_sig_reg;

    // ------------------------------------------------------------------
    // Tick decode
    // ------------------------------------------------------------------
    logic                  have_price;
    logic [PRICE_BITS-1:0] price;
    logic [EMA_BITS-1:0]   x_new;
    logic                  s_xfer;
    logic                  m_xfer;
    logic                  out_free;

    macs_price_select #(
        .PRICE_BITS (PRICE_BITS)
    ) u_price_select (
        .tick_kind   (s_tuser[1:0]),
        .bid_valid   (s_tuser[2]),
        .ask_valid   (s_tuser[3]),
        .trade_valid (s_tuser[4]),
        .bid_price   (s_tdata[PRICE_BITS-1:0]),
        .ask_price   (s_tdata[2*PRICE_BITS-1:PRICE_BITS]),
        .trade_price (s_tdata[3*PRICE_BITS-1:2*PRICE_BITS]),
        .have_price  (have_price),
        .price       (price)
    );

    // Prices enter the averages with the extra fraction bits appended.
    assign x_new    = {price, {EXTRA_FRAC_BITS{1'b0}}};
    assign s_xfer   = s_tvalid & s_tready;
    assign m_xfer   = m_valid_reg & m_tready;
    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Shared blend unit
    // ------------------------------------------------------------------
    blend_req_t                   blend_req;
    blend_rsp_t                   blend_rsp;
    logic signed [BLEND_BITS-1:0] blend_x;
    logic signed [BLEND_BITS-1:0] blend_y;
    logic signed [BLEND_BITS-1:0] blend_result;

    macs_blend_unit #(
        .VALUE_BITS (BLEND_BITS)
    ) u_blend (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (blend_req),
        .x_value (blend_x),
        .y_value (blend_y),
        .rsp     (blend_rsp),
        .result  (blend_result)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = have_price ? ST_FAST_GO : ST_OUTPUT;
                end
            end
            ST_FAST_GO:   state_next = ST_FAST_WAIT;
            ST_FAST_WAIT: begin
                if (blend_rsp.done) begin
                    state_next = ST_SLOW_GO;
                end
            end
            ST_SLOW_GO:   state_next = ST_SLOW_WAIT;
            ST_SLOW_WAIT: begin
                if (blend_rsp.done) begin
                    state_next = ST_MACD;
                end
            end
            ST_MACD:      state_next = ST_SIG_GO;
            ST_SIG_GO:    state_next = ST_SIG_WAIT;
            ST_SIG_WAIT: begin
                if (blend_rsp.done) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready        = 1'b0;
        blend_req.start = 1'b0;
        blend_req.alpha = clamp_alpha(alpha_fast_reg);
        blend_x         = BLEND_BITS'({2'b00, x_reg});
        blend_y         = BLEND_BITS'({2'b00, fast_reg});
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_FAST_GO: begin
                blend_req.start = 1'b1;
            end
            ST_SLOW_GO, ST_SLOW_WAIT: begin
                blend_req.start = (state_reg == ST_SLOW_GO);
                blend_req.alpha = clamp_alpha(alpha_slow_reg);
                blend_y         = BLEND_BITS'({2'b00, slow_reg});
            end
            ST_SIG_GO, ST_SIG_WAIT: begin
                // The signal line follows the MACD line just computed.
                blend_req.start = (state_reg == ST_SIG_GO);
                blend_req.alpha = clamp_alpha(alpha_signal_reg);
                blend_x         = BLEND_BITS'(macd_reg);
                blend_y         = BLEND_BITS'(trig_reg);
            end
            default: begin
                s_tready        = 1'b0;
                blend_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_fast_reg   <= ALPHA_FAST_RST;
            alpha_slow_reg   <= ALPHA_SLOW_RST;
            alpha_signal_reg <= ALPHA_SIGNAL_RST;
            warmup_reg       <= WARMUP_RST;
        end else if (cfg_valid && cfg_ready) begin
            // Writes to indexes beyond the register list are dropped.
            case (cfg_index)
                REG_ALPHA_FAST:   alpha_fast_reg   <= cfg_data[ALPHA_BITS-1:0];
                REG_ALPHA_SLOW:   alpha_slow_reg   <= cfg_data[ALPHA_BITS-1:0];
                REG_ALPHA_SIGNAL: alpha_signal_reg <= cfg_data[ALPHA_BITS-1:0];
                REG_WARMUP:       warmup_reg       <= cfg_data[WARMUP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Indicator datapath
    // ------------------------------------------------------------------
    logic cross_up;
    logic cross_down;
    logic [KIND_BITS-1:0] kind_w;
    logic signed [WIDE_BITS-1:0] macd_wide;
    logic signed [WIDE_BITS-1:0] trig_wide;

    assign cross_up   = (last_macd_reg < last_trig_reg) && (macd_reg > trig_reg);
    assign cross_down = (last_macd_reg > last_trig_reg) && (macd_reg < trig_reg);

    always_comb begin
        kind_w = SIG_HOLD;
        if (have_reg && armed_reg) begin
            if (cross_up) begin
                kind_w = SIG_BUY;
            end else if (cross_down) begin
                kind_w = SIG_SELL;
            end
        end
    end

    // Results carry the low output bits of the sign-extended lines.
    assign macd_wide = WIDE_BITS'(macd_reg);
    assign trig_wide = WIDE_BITS'(trig_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_reg   <= '0;
            slow_reg   <= '0;
            macd_reg   <= '0;
            trig_reg   <= '0;
            seeded_reg <= 1'b0;
            count_reg  <= '0;
            have_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        have_reg <= have_price;
                        if (have_price) begin
                            // The first price seeds both averages and
                            // zeroes the two lines before the normal update.
                            if (!seeded_reg) begin
                                fast_reg   <= x_new;
                                slow_reg   <= x_new;
                                macd_reg   <= '0;
                                trig_reg   <= '0;
                                seeded_reg <= 1'b1;
                            end
                            if (count_reg != '1) begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_FAST_WAIT: begin
                    if (blend_rsp.done) begin
                        fast_reg <= blend_result[EMA_BITS-1:0];
                    end
                end
                ST_SLOW_WAIT: begin
                    if (blend_rsp.done) begin
                        slow_reg <= blend_result[EMA_BITS-1:0];
                    end
                end
                ST_MACD: begin
                    macd_reg <= $signed({1'b0, fast_reg}) - $signed({1'b0, slow_reg});
                end
                ST_SIG_WAIT: begin
                    if (blend_rsp.done) begin
                        trig_reg <= blend_result[EMA_BITS:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working values captured with each tick.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_xfer) begin
            x_reg     <= x_new;
            armed_reg <= CMP_BITS'(count_reg) >= CMP_BITS'(warmup_reg);
            if (seeded_reg) begin
                last_macd_reg <= macd_reg;
                last_trig_reg <= trig_reg;
            end else begin
                last_macd_reg <= '0;
                last_trig_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUTPUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_xfer) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUTPUT && out_free) begin
            out_kind_reg <= kind_w;
            out_macd_reg <= macd_wide[OUT_BITS-1:0];
            out_sig_reg  <= trig_wide[OUT_BITS-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = M_DATA_BITS'({out_sig_reg, out_macd_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `MACS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_xfer, !s_tready,
        "input accepted while a tick is in progress")
    `MACS_ASSERT_NEXT(a_seeded_after_price, aclk, aresetn, s_xfer && have_price, seeded_reg,
        "priced tick did not seed the averages")
    `MACS_ASSERT(a_blend_in_wait, aclk, aresetn,
        !(blend_rsp.busy || blend_rsp.done) || state_reg == ST_FAST_WAIT ||
        state_reg == ST_SLOW_WAIT || state_reg == ST_SIG_WAIT,
        "blend unit active outside a wait state")
    `MACS_ASSERT(a_cross_needs_seed, aclk, aresetn,
        !(m_tvalid && m_tuser != SIG_HOLD) || seeded_reg,
        "crossover reported before any price was seen")

endmodule

`default_nettype wire

### design/macs_price_select.sv
// ----------------------------------------------------------------------------
// MACD crossover signal - price select
// Picks the usable price of a tick: quote mid or trade price.
// ----------------------------------------------------------------------------
`default_nettype none

module macs_price_select #(
    parameter int PRICE_BITS = 32
) (
    input  logic [macs_pkg::KIND_BITS-1:0] tick_kind,
    input  logic                           bid_valid,
    input  logic                           ask_valid,
    input  logic                           trade_valid,
    input  logic [PRICE_BITS-1:0]          bid_price,
    input  logic [PRICE_BITS-1:0]          ask_price,
    input  logic [PRICE_BITS-1:0]          trade_price,
    output logic                           have_price,
    output logic [PRICE_BITS-1:0]          price
);
    import macs_pkg::*;

    logic [PRICE_BITS:0] quote_sum;

    assign quote_sum = {1'b0, bid_price} + {1'b0, ask_price};

    always_comb begin
        have_price = 1'b0;
        price      = '0;
        case (tick_kind)
            TICK_QUOTE: begin
                // Truncated mid of the two sides.
                have_price = bid_valid & ask_valid;
                price      = quote_sum[PRICE_BITS:1];
            end
            TICK_TRADE: begin
                have_price = trade_valid;
                price      = trade_price;
            end
            default: begin
                have_price = 1'b0;
                price      = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/macs_blend_unit.sv
// ----------------------------------------------------------------------------
// MACD crossover signal - blend unit
// Iterative EMA step y + ((a * (x - y) + 2^15) >> 16) with one 18x33 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module macs_blend_unit #(
    parameter int VALUE_BITS = 50
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  macs_pkg::blend_req_t          req,
    input  logic signed [VALUE_BITS-1:0]  x_value,
    input  logic signed [VALUE_BITS-1:0]  y_value,
    output macs_pkg::blend_rsp_t          rsp,
    output logic signed [VALUE_BITS-1:0]  result
);
    import macs_pkg::*;

    localparam int CHUNK     = 32;
    localparam int NCH       = (VALUE_BITS + CHUNK - 1) / CHUNK;
    localparam int PADW      = NCH * CHUNK;
    localparam int ACCW      = PADW + ALPHA_BITS + 1;
    localparam int PRODW     = ALPHA_BITS + 1 + CHUNK + 1;
    localparam int STEP_BITS = $clog2(NCH + 3);

    localparam logic [STEP_BITS-1:0] LAST_MUL  = STEP_BITS'(NCH - 1);
    localparam logic [STEP_BITS-1:0] LAST_ACC  = STEP_BITS'(NCH);
    localparam logic [STEP_BITS-1:0] ROUND_STP = STEP_BITS'(NCH + 1);
    localparam logic [STEP_BITS-1:0] FINAL_STP = STEP_BITS'(NCH + 2);
    localparam logic signed [ACCW-1:0] HALF    = ACCW'(1 << (ALPHA_FRAC - 1));

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_BITS-1:0]         step_reg;
    logic [ALPHA_BITS-1:0]        alpha_reg;
    logic signed [VALUE_BITS-1:0] y_reg;
    logic [PADW-1:0]              diff_reg;
    logic signed [PRODW-1:0]      prod_reg;
    logic signed [ACCW-1:0]       acc_reg;
    logic signed [VALUE_BITS-1:0] result_reg;

    logic signed [VALUE_BITS-1:0] diff_w;
    logic [CHUNK-1:0]             chunk;
    logic signed [CHUNK:0]        chunk_ext;
    logic signed [ALPHA_BITS:0]   alpha_s;
    logic signed [PRODW-1:0]      prod_w;

    assign diff_w  = x_value - y_value;
    assign chunk   = diff_reg[PADW-1 -: CHUNK];
    // The top chunk carries the sign; lower chunks are plain magnitudes.
    assign chunk_ext = (step_reg == '0) ? {chunk[CHUNK-1], chunk} : {1'b0, chunk};
    assign alpha_s = {1'b0, alpha_reg};
    assign prod_w  = alpha_s * chunk_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && (step_reg == FINAL_STP);
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == FINAL_STP) begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            alpha_reg <= req.alpha;
            y_reg     <= y_value;
            diff_reg  <= PADW'(diff_w);
            acc_reg   <= '0;
        end else if (busy_reg) begin
            if (step_reg <= LAST_MUL) begin
                prod_reg <= prod_w;
                diff_reg <= diff_reg << CHUNK;
            end
            if (step_reg != '0 && step_reg <= LAST_ACC) begin
                acc_reg <= (acc_reg <<< CHUNK) + ACCW'(prod_reg);
            end
            if (step_reg == ROUND_STP) begin
                acc_reg <= acc_reg + HALF;
            end
            if (step_reg == FINAL_STP) begin
                result_reg <= y_reg + VALUE_BITS'(acc_reg >>> ALPHA_FRAC);
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = result_reg;

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD crossover signal - block-level testbench
// Streams market ticks into the block under random back-pressure, predicts
// the fast, slow and signal EMAs, the MACD line and the BUY/SELL verdict for
// every tick, and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import macs_pkg::*;

    // Bus geometry at the default parameters.
    localparam int S_DATA_BITS = ((3 * PRICE_BITS_DEF + 7) / 8) * 8;

    // Fixed-point constants of the EMA datapath.
    localparam logic [ALPHA_BITS-1:0] UNITY_Q16   = 17'd65536;
    localparam longint                SIGNED_BIAS = 64'h0001_0000_0000_0000;
    localparam logic [15:0]           COUNT_FULL  = 16'hFFFF;

    // The tick kind that the block treats like "none".
    localparam logic [KIND_BITS-1:0] TICK_OTHER = 2'd3;

    // Register indexes that name no register.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_TOP = 8'hFF;

    // Cycles to wait once the block has gone quiet.
    localparam int SETTLE_CYCLES = 40;
    // Timeout in nanoseconds, many times the slowest legal run.
    localparam int TIMEOUT_NS    = 4_000_000;

    typedef struct {
        logic [KIND_BITS-1:0] kind;
        logic                 bid_ok;
        logic                 ask_ok;
        logic                 trade_ok;
        logic [31:0]          bid_price;
        logic [31:0]          ask_price;
        logic [31:0]          trade_price;
    } tick_t;

    typedef struct {
        logic [KIND_BITS-1:0] kind;
        logic [OUT_BITS-1:0]  macd;
        logic [OUT_BITS-1:0]  trigger;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_DATA_BITS-1:0]    s_tdata   = '0;
    logic [S_USER_BITS-1:0]    s_tuser   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_DATA_BITS-1:0]    m_tdata;
    logic [M_USER_BITS-1:0]    m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // When set, neither side of the stream idles.
    bit calm = 1'b0;
    int fail_count = 0;

    tick_t    pending_ticks[$];
    verdict_t expected_verdicts[$];
    tick_t    tick_on_bus;
    tick_t    staged_tick;

    // Predictor copy of the configuration registers.
    logic [ALPHA_BITS-1:0]  w_fast;
    logic [ALPHA_BITS-1:0]  w_slow;
    logic [ALPHA_BITS-1:0]  w_signal;
    logic [WARMUP_BITS-1:0] warmup_ticks;

    // Predictor copy of the block's state.
    logic [47:0]                fast_ema;
    logic [47:0]                slow_ema;
    logic signed [OUT_BITS-1:0] macd_now;
    logic signed [OUT_BITS-1:0] trigger_now;
    bit                         primed;
    logic [15:0]                price_count;

    macd_crossover_signal i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // One EMA step, (w*x + (1-w)*y + 1/2) with w in Q1.16, done exactly in a wide
    // accumulator so it rounds half up. Weights above one behave as one.
    function automatic logic [63:0] ema_blend(input logic [ALPHA_BITS-1:0] weight,
                                              input logic [63:0] x,
                                              input logic [63:0] y);
        logic [ALPHA_BITS-1:0] w;
        logic [87:0]           acc;
        w   = (weight > UNITY_Q16) ? UNITY_Q16 : weight;
        acc = 88'(w) * 88'(x) + 88'(UNITY_Q16 - w) * 88'(y) + 88'd32768;
        return acc[79:16];
    endfunction

    task automatic restore_defaults();
        w_fast       = ALPHA_FAST_RST;
        w_slow       = ALPHA_SLOW_RST;
        w_signal     = ALPHA_SIGNAL_RST;
        warmup_ticks = WARMUP_RST;
        fast_ema     = '0;
        slow_ema     = '0;
        macd_now     = '0;
        trigger_now  = '0;
        primed       = 1'b0;
        price_count  = '0;
    endtask

    // A register write lands in the predictor only for a known index; any
    // other index is dropped, just as the block drops it.
    task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_ALPHA_FAST:   w_fast       = value[ALPHA_BITS-1:0];
            REG_ALPHA_SLOW:   w_slow       = value[ALPHA_BITS-1:0];
            REG_ALPHA_SIGNAL: w_signal     = value[ALPHA_BITS-1:0];
            REG_WARMUP:       warmup_ticks = value[WARMUP_BITS-1:0];
            default: ;
        endcase
    endtask

    // Work out the result of one accepted tick and queue it.
    task automatic predict_signal(input tick_t t);
        bit                         has_price;
        bit                         armed;
        logic [31:0]                px;
        logic [63:0]                x;
        logic [63:0]                blended;
        longint                     shifted;
        logic signed [OUT_BITS-1:0] last_macd;
        logic signed [OUT_BITS-1:0] last_trigger;
        verdict_t                   v;

        has_price = 1'b0;
        px        = '0;
        v.kind    = SIG_HOLD;
        // A quote needs both sides; its price is the truncated mid.
        if (t.kind == TICK_QUOTE && t.bid_ok && t.ask_ok) begin
            px        = 32'(({1'b0, t.bid_price} + {1'b0, t.ask_price}) >> 1);
            has_price = 1'b1;
        end else if (t.kind == TICK_TRADE && t.trade_ok) begin
            px        = t.trade_price;
            has_price = 1'b1;
        end

        if (has_price) begin
            x = {16'h0000, px, 16'h0000};
            // The very first price pulls both averages onto itself.
            if (!primed) begin
                fast_ema    = x[47:0];
                slow_ema    = x[47:0];
                macd_now    = '0;
                trigger_now = '0;
                primed      = 1'b1;
            end
            blended  = ema_blend(w_fast, x, {16'h0000, fast_ema});
            fast_ema = blended[47:0];
            blended  = ema_blend(w_slow, x, {16'h0000, slow_ema});
            slow_ema = blended[47:0];

            last_macd    = macd_now;
            last_trigger = trigger_now;
            macd_now     = $signed({1'b0, fast_ema}) - $signed({1'b0, slow_ema});
            // The signal EMA works on biased, non-negative copies of the lines.
            blended      = ema_blend(w_signal,
                                     64'(longint'(macd_now) + SIGNED_BIAS),
                                     64'(longint'(trigger_now) + SIGNED_BIAS));
            shifted      = longint'(blended) - SIGNED_BIAS;
            trigger_now  = shifted[OUT_BITS-1:0];

            // Crossovers count only once the warmup has passed.
            armed = (price_count >= warmup_ticks);
            if (price_count != COUNT_FULL) begin
                price_count = price_count + 16'd1;
            end
            if (armed) begin
                if (last_macd < last_trigger && macd_now > trigger_now) begin
                    v.kind = SIG_BUY;
                end else if (last_macd > last_trigger && macd_now < trigger_now) begin
                    v.kind = SIG_SELL;
                end
            end
        end

        v.macd    = macd_now;
        v.trigger = trigger_now;
        expected_verdicts.push_back(v);
    endtask

    // ------------------------------------------------------------------------
    // Tick driver. A new tick is offered whenever the bus slot is free, unless
    // the sender idles this cycle. The prediction is made at the very edge
    // where the transfer happens, from the copy held on the bus.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_signal(tick_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= 37)) begin
                    staged_tick = pending_ticks.pop_front();
                    tick_on_bus <= staged_tick;
                    s_tvalid    <= 1'b1;
                    s_tdata     <= {staged_tick.trade_price, staged_tick.ask_price,
                                    staged_tick.bid_price};
                    s_tuser     <= {staged_tick.trade_ok, staged_tick.ask_ok,
                                    staged_tick.bid_ok, staged_tick.kind};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_verdict(input verdict_t v);
        logic [OUT_BITS-1:0] got_macd;
        logic [OUT_BITS-1:0] got_trigger;
        got_macd    = m_tdata[OUT_BITS-1:0];
        got_trigger = m_tdata[2*OUT_BITS-1:OUT_BITS];
        if (m_tuser !== v.kind) begin
            $error("signal_kind mismatch: expected %0d, got %0d", v.kind, m_tuser);
            fail_count++;
        end
        if (got_macd !== v.macd) begin
            $error("macd_value mismatch: expected %0d, got %0d",
                   $signed(v.macd), $signed(got_macd));
            fail_count++;
        end
        if (got_trigger !== v.trigger) begin
            $error("signal_line mismatch: expected %0d, got %0d",
                   $signed(v.trigger), $signed(got_trigger));
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result monitor. Each result transfer is matched with the oldest
    // prediction, field by field; m_tready is stalled at random.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result transfer with no tick waiting for it");
                    fail_count++;
                end else begin
                    check_verdict(expected_verdicts.pop_front());
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 37);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_tick(input logic [KIND_BITS-1:0] kind,
                             input logic bid_ok, input logic ask_ok, input logic trade_ok,
                             input logic [31:0] bid, input logic [31:0] ask,
                             input logic [31:0] trade);
        tick_t t;
        t.kind        = kind;
        t.bid_ok      = bid_ok;
        t.ask_ok      = ask_ok;
        t.trade_ok    = trade_ok;
        t.bid_price   = bid;
        t.ask_price   = ask;
        t.trade_price = trade;
        pending_ticks.push_back(t);
    endtask

    // Wait until every queued tick has made its transfer and every result has
    // come back, then give the block a little longer to fall idle.
    task automatic settle();
        while (pending_ticks.size() != 0 || s_tvalid || expected_verdicts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register write; called at a rising edge. The valid line stays high
    // across back-to-back writes and is lowered by the caller afterwards.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        apply_register(idx, value);
    endtask

    task automatic load_weights(input logic [CFG_DATA_BITS-1:0] fast,
                                input logic [CFG_DATA_BITS-1:0] slow,
                                input logic [CFG_DATA_BITS-1:0] trig,
                                input logic [CFG_DATA_BITS-1:0] warmup);
        write_register(REG_ALPHA_FAST, fast);
        write_register(REG_ALPHA_SLOW, slow);
        write_register(REG_ALPHA_SIGNAL, trig);
        write_register(REG_WARMUP, warmup);
        cfg_valid <= 1'b0;
    endtask

    // A random-walk market whose direction flips now and then, so the MACD
    // line keeps crossing its signal line. About one tick in ten carries no
    // usable price and one in twenty is an outlier with fully random prices.
    task automatic run_market(input int priced_goal);
        int          made;
        int          pick;
        bit          rising;
        logic [31:0] level;
        logic [31:0] step;
        logic [31:0] spread;
        tick_t       t;

        made   = 0;
        level  = $urandom_range(32'h0010_0000, 32'h7FFF_FFFF);
        rising = $urandom_range(0, 1);
        while (made < priced_goal) begin
            pick          = $urandom_range(0, 99);
            t.bid_price   = $urandom;
            t.ask_price   = $urandom;
            t.trade_price = $urandom;
            t.bid_ok      = $urandom_range(0, 1);
            t.ask_ok      = $urandom_range(0, 1);
            t.trade_ok    = $urandom_range(0, 1);
            if (pick < 10) begin
                // Broken tick: the block must answer HOLD and keep its state.
                case ($urandom_range(0, 3))
                    0: t.kind = TICK_NONE;
                    1: t.kind = TICK_OTHER;
                    2: begin
                        t.kind = TICK_QUOTE;
                        if ($urandom_range(0, 1)) begin
                            t.bid_ok = 1'b0;
                        end else begin
                            t.ask_ok = 1'b0;
                        end
                    end
                    default: begin
                        t.kind     = TICK_TRADE;
                        t.trade_ok = 1'b0;
                    end
                endcase
            end else if (pick < 15) begin
                if ($urandom_range(0, 1)) begin
                    t.kind   = TICK_QUOTE;
                    t.bid_ok = 1'b1;
                    t.ask_ok = 1'b1;
                end else begin
                    t.kind     = TICK_TRADE;
                    t.trade_ok = 1'b1;
                end
                made++;
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    rising = !rising;
                end
                step  = $urandom_range(0, 32'd1 << $urandom_range(4, 18));
                level = rising ? level + step : level - step;
                if ($urandom_range(0, 1)) begin
                    spread      = $urandom_range(0, 255);
                    t.kind      = TICK_QUOTE;
                    t.bid_ok    = 1'b1;
                    t.ask_ok    = 1'b1;
                    t.bid_price = level - spread;
                    t.ask_price = level + spread;
                end else begin
                    t.kind        = TICK_TRADE;
                    t.trade_ok    = 1'b1;
                    t.trade_price = level;
                end
                made++;
            end
            pending_ticks.push_back(t);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        restore_defaults();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed ticks at the reset settings. Before the first price, ticks
        // without a usable price must report HOLD with both lines at zero.
        push_tick(TICK_NONE,  1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_tick(TICK_OTHER, 1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_tick(TICK_QUOTE, 1, 0, 1, 32'h0000_1000, 32'h0000_2000, 32'h0000_3000);
        push_tick(TICK_QUOTE, 0, 1, 1, 32'h0000_1000, 32'h0000_2000, 32'h0000_3000);
        push_tick(TICK_TRADE, 1, 1, 0, 32'h0000_1000, 32'h0000_2000, 32'h0000_3000);
        // Seeding with a zero price, then the largest trade price.
        push_tick(TICK_TRADE, 0, 0, 1, 32'h0, 32'h0, 32'h0);
        push_tick(TICK_TRADE, 0, 0, 1, 32'h0, 32'h0, 32'hFFFF_FFFF);
        // Mid prices: the carry of the sum must survive the halving.
        push_tick(TICK_QUOTE, 1, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        push_tick(TICK_QUOTE, 1, 1, 0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        push_tick(TICK_QUOTE, 1, 1, 1, 32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF);
        // Unpriced ticks after seeding repeat the current lines.
        push_tick(TICK_NONE,  0, 0, 0, 32'h0, 32'h0, 32'h0);
        push_tick(TICK_TRADE, 1, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) begin
            push_tick(TICK_TRADE, 0, 0, 1, 32'h0, 32'h0, (i % 2) ? 32'hFFFF_FFFF : 32'h0);
        end
        settle();

        // Crossovers armed at once, weights at their reset values.
        load_weights(ALPHA_FAST_RST, ALPHA_SLOW_RST, ALPHA_SIGNAL_RST, 32'd0);
        run_market(105);
        settle();

        // Extreme weights: full weight, zero weight, and an over-range value
        // whose upper data bits are dropped and which then acts as one. The
        // warmup is pushed to its maximum, and writes to unknown indexes must
        // change nothing.
        load_weights(32'd65536, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_register(REG_UNUSED_LOW, $urandom);
        write_register(REG_UNUSED_TOP, $urandom);
        cfg_valid <= 1'b0;
        run_market(105);
        settle();

        // A warmup that runs out part way through this phase.
        load_weights(32'd30000, 32'd3000, 32'd20000, 32'(price_count) + 32'd60);
        run_market(105);
        settle();

        // Frozen fast and signal averages, the slow one tracks every price.
        load_weights(32'd0, 32'd65536, 32'd0, 32'd0);
        run_market(105);
        settle();

        // Final phase with no idling on either side.
        calm = 1'b1;
        load_weights(32'd20000, 32'd6000, 32'd26000, 32'd0);
        run_market(105);
        settle();

        if (fail_count == 0 && expected_verdicts.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: a missing result or a hung handshake ends the run here.
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
